FILE: sv/sfdm_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the sampled frequency and duty meter
package sfdm_pkg;

    localparam int COUNT_WIDTH_DEF  = 20;
    localparam int PCOUNT_WIDTH_DEF = 16;

    localparam int SP_W = 10;
    localparam logic [SP_W-1:0] SP_RESET = 10'd10;

    localparam int FREQ_W = 27;
    localparam logic [FREQ_W-1:0] FREQ_MAX = 27'h7FF_FFFF;

    localparam int SCALED_MHZ_W = 28;
    localparam logic [SCALED_MHZ_W-1:0] SCALED_MHZ = 28'd256000000;

    localparam int DUTY_W = 15;
    localparam logic [DUTY_W-1:0] DUTY_SCALE = 15'd25600;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: sv/sfdm_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module sfdm_div #(
    parameter int DIVIDEND_W = 43,
    parameter int DIVISOR_W  = 31
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]    divisor,
    output logic [DIVIDEND_W-1:0]   quotient,
    output sfdm_pkg::div_status_t   status
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quot_reg, quot_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    // quot_reg shifts dividend bits out at the top and quotient bits in at the bottom
    assign shifted = {rem_reg, quot_reg[DIVIDEND_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[DIVIDEND_W-2:0], ge};
            rem_next  = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg == CNT_W'(1) |=> done_reg && !busy_reg)
        else $error("divider did not finish on its last step");

endmodule

FILE: sv/sampled_frequency_duty_meter.sv
`timescale 1ns / 1ps
// top level of the sampled frequency and duty meter
//
// s_* takes one sampled level per item in s_tdata[0]. Every second level
// change after the first closes a period and yields one item on m_*: period,
// high samples, duty in percent and frequency in Hz (both with 8 fraction
// bits), the mean of this and the previous frequency, the running mean and
// the number of periods in it.
// cfg_wr_en/cfg_wr_data write the sample interval in microseconds; write it
// only while the block is idle.
// An item that closes no period is accepted at once, and s_tready stays high.
// An item that closes a period runs three divisions through one shared
// restoring divider, one quotient bit per cycle, before the result is
// loaded into the output register. s_tready is low meanwhile.
// A result waits in the output register while m_tready is low; the next
// items are accepted then, but a further closing item holds at its end
// until the register is free.
// Reset clears all counts, the running sum and the output valid flag, and
// sets the sample interval to 10 us.
module sampled_frequency_duty_meter #(
    parameter int COUNT_WIDTH        = sfdm_pkg::COUNT_WIDTH_DEF,
    parameter int PERIOD_COUNT_WIDTH = sfdm_pkg::PCOUNT_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [sfdm_pkg::SP_W-1:0] cfg_wr_data,    // sample_period_us
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,         // sample_level
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // period_samples, high_samples, duty_percent, frequency_hz,
    // pair_average_hz, running_average_hz, periods_measured
    output logic [((2*COUNT_WIDTH + PERIOD_COUNT_WIDTH + 3*sfdm_pkg::FREQ_W
                    + sfdm_pkg::DUTY_W + 8) / 8) * 8 - 1:0] m_tdata
);

    localparam int CW      = COUNT_WIDTH;
    localparam int PCW     = PERIOD_COUNT_WIDTH;
    localparam int FW      = sfdm_pkg::FREQ_W;
    localparam int DW      = sfdm_pkg::DUTY_W;
    localparam int PER_W   = CW + 1;
    localparam int PROD_W  = PER_W + sfdm_pkg::SP_W;
    localparam int SUM_W   = FW + PCW;
    localparam int RAW_W   = PER_W + CW + DW + 3*FW + PCW;
    localparam int OUT_W   = ((RAW_W + 7) / 8) * 8;
    localparam int DUTYA_W = CW + DW;
    localparam int DIV_A_W = (DUTYA_W > SUM_W) ?
                             ((DUTYA_W > sfdm_pkg::SCALED_MHZ_W) ? DUTYA_W
                                                                 : sfdm_pkg::SCALED_MHZ_W) :
                             ((SUM_W > sfdm_pkg::SCALED_MHZ_W) ? SUM_W
                                                               : sfdm_pkg::SCALED_MHZ_W);
    localparam int DIV_B_W = (PROD_W > PCW) ? PROD_W : PCW;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DUTY_GO   = 4'd1;
    localparam logic [3:0] ST_DUTY_WAIT = 4'd2;
    localparam logic [3:0] ST_FREQ_GO   = 4'd3;
    localparam logic [3:0] ST_FREQ_WAIT = 4'd4;
    localparam logic [3:0] ST_SUM       = 4'd5;
    localparam logic [3:0] ST_MEAN_GO   = 4'd6;
    localparam logic [3:0] ST_MEAN_WAIT = 4'd7;
    localparam logic [3:0] ST_OUT       = 4'd8;

    logic [3:0]              state_reg, state_next;
    logic [sfdm_pkg::SP_W-1:0] sp_reg, sp_next;
    logic                    seen_reg, seen_next;
    logic                    prev_level_reg, prev_level_next;
    logic                    waiting_reg, waiting_next;
    logic                    parity_reg, parity_next;
    logic [CW-1:0]           low_reg, low_next;
    logic [CW-1:0]           high_reg, high_next;
    logic [FW-1:0]           prev_freq_reg, prev_freq_next;
    logic                    have_prev_reg, have_prev_next;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [PCW-1:0]          pcount_reg, pcount_next;
    logic [PER_W-1:0]        period_reg, period_next;
    logic [CW-1:0]           highw_reg, highw_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [DW-1:0]           duty_reg, duty_next;
    logic [FW-1:0]           freq_reg, freq_next;
    logic [FW-1:0]           mean_reg, mean_next;
    logic [OUT_W-1:0]        out_data_reg, out_data_next;
    logic                    out_valid_reg, out_valid_next;

    logic                    accept;
    logic                    level;
    logic                    prev_eff;
    logic                    level_change;
    logic                    closing;
    logic [CW-1:0]           low_base;
    logic [CW-1:0]           high_base;
    logic [FW:0]             pair_sum;
    logic [FW-1:0]           pair;
    logic                    out_free;

    logic                    div_start;
    logic [DIV_A_W-1:0]      div_a;
    logic [DIV_B_W-1:0]      div_b;
    logic [DIV_A_W-1:0]      div_q;
    sfdm_pkg::div_status_t   div_st;

    sfdm_div #(
        .DIVIDEND_W (DIV_A_W),
        .DIVISOR_W  (DIV_B_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .status   (div_st)
    );

    assign accept       = (state_reg == ST_IDLE) && s_tvalid;
    assign level        = s_tdata[0];
    assign prev_eff     = seen_reg ? prev_level_reg : level;
    assign level_change = level != prev_eff;
    assign closing      = level_change && !waiting_reg && parity_reg;
    // first edge and a closing edge restart both counts
    assign low_base     = (level_change && (waiting_reg || closing)) ? '0 : low_reg;
    assign high_base    = (level_change && (waiting_reg || closing)) ? '0 : high_reg;
    assign pair_sum     = {1'b0, freq_reg} + {1'b0, prev_freq_reg};
    assign pair         = have_prev_reg ? pair_sum[FW:1] : freq_reg;
    assign out_free     = !out_valid_reg || m_tready;

    always_comb
    begin
        div_start = 1'b0;
        div_a     = DIV_A_W'(highw_reg) * DIV_A_W'(sfdm_pkg::DUTY_SCALE);
        div_b     = DIV_B_W'(period_reg);
        case (state_reg)
            ST_DUTY_GO:
            begin
                div_start = 1'b1;
            end
            ST_FREQ_GO:
            begin
                div_start = 1'b1;
                div_a     = DIV_A_W'(sfdm_pkg::SCALED_MHZ);
                div_b     = DIV_B_W'(prod_reg);
            end
            ST_MEAN_GO:
            begin
                div_start = 1'b1;
                div_a     = DIV_A_W'(sum_reg);
                div_b     = DIV_B_W'(pcount_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        sp_next         = cfg_wr_en ? cfg_wr_data : sp_reg;
        seen_next       = seen_reg;
        prev_level_next = prev_level_reg;
        waiting_next    = waiting_reg;
        parity_next     = parity_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        prev_freq_next  = prev_freq_reg;
        have_prev_next  = have_prev_reg;
        sum_next        = sum_reg;
        pcount_next     = pcount_reg;
        period_next     = period_reg;
        highw_next      = highw_reg;
        prod_next       = prod_reg;
        duty_next       = duty_reg;
        freq_next       = freq_reg;
        mean_next       = mean_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !m_tready;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    seen_next       = 1'b1;
                    prev_level_next = level;
                    if (level_change)
                    begin
                        waiting_next = 1'b0;
                        if (!waiting_reg)
                        begin
                            parity_next = !parity_reg;
                        end
                    end
                    low_next  = low_base;
                    high_next = high_base;
                    if (level)
                    begin
                        high_next = (&high_base) ? high_base : high_base + CW'(1);
                    end
                    else
                    begin
                        low_next = (&low_base) ? low_base : low_base + CW'(1);
                    end
                    if (closing)
                    begin
                        period_next = {1'b0, low_reg} + {1'b0, high_reg};
                        highw_next  = high_reg;
                        state_next  = ST_DUTY_GO;
                    end
                end
            end
            ST_DUTY_GO:
            begin
                prod_next  = PROD_W'(period_reg) * PROD_W'(sp_reg);
                state_next = ST_DUTY_WAIT;
            end
            ST_DUTY_WAIT:
            begin
                if (div_st.done)
                begin
                    duty_next  = (period_reg == '0) ? '0 : div_q[DW-1:0];
                    state_next = ST_FREQ_GO;
                end
            end
            ST_FREQ_GO:
            begin
                state_next = ST_FREQ_WAIT;
            end
            ST_FREQ_WAIT:
            begin
                if (div_st.done)
                begin
                    if (prod_reg == '0 || div_q > DIV_A_W'(sfdm_pkg::FREQ_MAX))
                    begin
                        freq_next = sfdm_pkg::FREQ_MAX;
                    end
                    else
                    begin
                        freq_next = div_q[FW-1:0];
                    end
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                // sum and count freeze once the count is full
                if (!(&pcount_reg))
                begin
                    sum_next    = sum_reg + SUM_W'(freq_reg);
                    pcount_next = pcount_reg + PCW'(1);
                end
                state_next = ST_MEAN_GO;
            end
            ST_MEAN_GO:
            begin
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (div_st.done)
                begin
                    mean_next  = (pcount_reg == '0) ? '0 : div_q[FW-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_data_next  = OUT_W'({pcount_reg, mean_reg, pair, freq_reg,
                                             duty_reg, highw_reg, period_reg});
                    out_valid_next = 1'b1;
                    prev_freq_next = freq_reg;
                    have_prev_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sp_reg         <= sfdm_pkg::SP_RESET;
            seen_reg       <= 1'b0;
            prev_level_reg <= 1'b0;
            waiting_reg    <= 1'b1;
            parity_reg     <= 1'b0;
            low_reg        <= '0;
            high_reg       <= '0;
            prev_freq_reg  <= '0;
            have_prev_reg  <= 1'b0;
            sum_reg        <= '0;
            pcount_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sp_reg         <= sp_next;
            seen_reg       <= seen_next;
            prev_level_reg <= prev_level_next;
            waiting_reg    <= waiting_next;
            parity_reg     <= parity_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            prev_freq_reg  <= prev_freq_next;
            have_prev_reg  <= have_prev_next;
            sum_reg        <= sum_next;
            pcount_reg     <= pcount_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg   <= period_next;
        highw_reg    <= highw_next;
        prod_reg     <= prod_next;
        duty_reg     <= duty_next;
        freq_reg     <= freq_next;
        mean_reg     <= mean_next;
        out_data_reg <= out_data_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_OUT && out_free |=> m_tvalid && state_reg == ST_IDLE)
        else $error("result not loaded into the output register");

    a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_data_reg[PER_W + CW + DW - 1 : PER_W + CW] <= sfdm_pkg::DUTY_SCALE)
        else $error("duty above full scale");

    a_busy_only_working: assert property (@(posedge clk) disable iff (!rst_n)
        div_st.busy |-> state_reg == ST_DUTY_WAIT || state_reg == ST_FREQ_WAIT
                        || state_reg == ST_MEAN_WAIT)
        else $error("divider running outside a wait state");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench of the sampled frequency and duty meter
module tb_top;

    localparam int CNT_W  = sfdm_pkg::COUNT_WIDTH_DEF;
    localparam int PCNT_W = sfdm_pkg::PCOUNT_WIDTH_DEF;
    localparam int FW     = sfdm_pkg::FREQ_W;
    localparam int DW     = sfdm_pkg::DUTY_W;
    localparam int SPW    = sfdm_pkg::SP_W;
    localparam int M_W    = ((2*CNT_W + PCNT_W + 3*FW + DW + 8) / 8) * 8;
    localparam longint unsigned CNT_MAX  = (64'd1 << CNT_W) - 1;
    localparam longint unsigned PCNT_MAX = (64'd1 << PCNT_W) - 1;
    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_LIMIT   = 50000;

    // fields from the lowest bit up: period, high, duty, freq, pair, running, periods
    typedef struct packed {
        logic [PCNT_W-1:0] periods;
        logic [FW-1:0]     running_avg;
        logic [FW-1:0]     pair_avg;
        logic [FW-1:0]     freq;
        logic [DW-1:0]     duty;
        logic [CNT_W-1:0]  high;
        logic [CNT_W:0]    period;
    } meter_result_t;

    localparam int RES_W = $bits(meter_result_t);

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_wr_en = 1'b0;
    logic [SPW-1:0]  cfg_wr_data = '0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [7:0]      s_tdata = 8'd0;     // sample_level
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    // period_samples, high_samples, duty_percent, frequency_hz,
    // pair_average_hz, running_average_hz, periods_measured
    logic [M_W-1:0]  m_tdata;

    sampled_frequency_duty_meter DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // meter model state
    logic [SPW-1:0]    interval_us;
    bit                seeded;
    bit                last_level;
    bit                first_edge_pending;
    bit                half_period;
    bit                have_last_freq;
    longint unsigned   low_cnt;
    longint unsigned   high_cnt;
    longint unsigned   last_freq;
    longint unsigned   freq_sum;
    longint unsigned   period_cnt;

    meter_result_t     expected_q[$];
    bit                sample_q[$];
    bit                last_pushed;

    bit                s_taken;
    bit                m_taken;
    bit                src_burst;
    bit                snk_burst;
    int                src_gap;
    int                snk_wait;

    int                mismatches;
    int                results_checked;
    int                samples_seen;
    int                settings_used;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned count_up(longint unsigned v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 1;
    endfunction

    function automatic void meter_step(bit lvl);
        longint unsigned per;
        longint unsigned duty;
        longint unsigned prod;
        longint unsigned freq;
        longint unsigned pair;
        longint unsigned mean;
        meter_result_t   r;
        if (!seeded)
        begin
            seeded = 1'b1;
            last_level = lvl;
        end
        if (lvl != last_level)
        begin
            if (first_edge_pending)
            begin
                // partial counts before the first edge are dropped
                first_edge_pending = 1'b0;
                low_cnt = 0;
                high_cnt = 0;
            end
            else if (!half_period)
                half_period = 1'b1;
            else
            begin
                per  = low_cnt + high_cnt;
                duty = (per != 0) ? (high_cnt * sfdm_pkg::DUTY_SCALE) / per : 0;
                prod = per * interval_us;
                if (prod == 0)
                    freq = 64'(sfdm_pkg::FREQ_MAX);
                else
                begin
                    freq = sfdm_pkg::SCALED_MHZ / prod;
                    if (freq > sfdm_pkg::FREQ_MAX)
                        freq = 64'(sfdm_pkg::FREQ_MAX);
                end
                if (period_cnt < PCNT_MAX)
                begin
                    freq_sum += freq;
                    period_cnt += 1;
                end
                pair = have_last_freq ? (freq + last_freq) >> 1 : freq;
                mean = (period_cnt != 0) ? freq_sum / period_cnt : 0;
                r.period      = (CNT_W+1)'(per);
                r.high        = CNT_W'(high_cnt);
                r.duty        = DW'(duty);
                r.freq        = FW'(freq);
                r.pair_avg    = FW'(pair);
                r.running_avg = FW'(mean);
                r.periods     = PCNT_W'(period_cnt);
                expected_q.push_back(r);
                last_freq = freq;
                have_last_freq = 1'b1;
                low_cnt = 0;
                high_cnt = 0;
                half_period = 1'b0;
            end
        end
        last_level = lvl;
        if (lvl == 1'b0)
            low_cnt = count_up(low_cnt);
        else
            high_cnt = count_up(high_cnt);
    endfunction

    task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    // monitor: acceptance on both sides and result checking
    always @(posedge clk)
    begin
        meter_result_t got;
        meter_result_t want;
        if (rst_n)
        begin
            s_taken <= s_tvalid && s_tready;
            m_taken <= m_tvalid && m_tready;
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[RES_W-1:0];
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with none expected, period %0d",
                                 $time, got.period);
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("period_samples", 64'(want.period), 64'(got.period));
                    check_field("high_samples", 64'(want.high), 64'(got.high));
                    check_field("duty_percent", 64'(want.duty), 64'(got.duty));
                    check_field("frequency_hz", 64'(want.freq), 64'(got.freq));
                    check_field("pair_average_hz", 64'(want.pair_avg),
                                64'(got.pair_avg));
                    check_field("running_average_hz", 64'(want.running_avg),
                                64'(got.running_avg));
                    check_field("periods_measured", 64'(want.periods),
                                64'(got.periods));
                    results_checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                meter_step(s_tdata[0]);
                samples_seen++;
            end
        end
    end

    // sample driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                s_tdata  <= {7'd0, sample_q.pop_front()};
                s_tvalid <= 1'b1;
                src_gap  = src_burst ? 0 : $urandom_range(0, 7);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // result sink: draws a random stall after each item it takes, none in burst mode
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_taken)
                snk_wait = snk_burst ? 0 : $urandom_range(0, 7);
            m_tready <= (snk_wait == 0);
            if (snk_wait > 0 && m_tvalid)
                snk_wait--;
        end
    end

    task automatic set_interval(logic [SPW-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        interval_us = v;
        settings_used++;
    endtask

    task automatic add_run(bit lvl, int n);
        repeat (n) sample_q.push_back(lvl);
        last_pushed = lvl;
    endtask

    task automatic add_levels(bit lvls[$]);
        foreach (lvls[i])
            add_run(lvls[i], 1);
    endtask

    // mostly alternating runs, some single random levels as noise
    task automatic gen_phase(int n_items);
        int added;
        int len;
        bit lvl;
        added = 0;
        while (added < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                if ($urandom_range(0, 19) == 0)
                    len = $urandom_range(9, 100);
                else
                    len = $urandom_range(1, 8);
                add_run(!last_pushed, len);
                added += len;
            end
            else
            begin
                lvl = 1'($urandom_range(0, 1));
                add_run(lvl, 1);
                added++;
            end
        end
    endtask

    // wait until every sample is sent and every expected result is in, then let the block settle
    task automatic drain();
        int waited;
        waited = 0;
        while ((sample_q.size() != 0 || s_tvalid || expected_q.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (waited >= DRAIN_LIMIT)
        begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, expected_q.size());
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [SPW-1:0] intervals[7];
        interval_us        = sfdm_pkg::SP_RESET;
        seeded             = 1'b0;
        last_level         = 1'b0;
        first_edge_pending = 1'b1;
        half_period        = 1'b0;
        have_last_freq     = 1'b0;
        low_cnt            = 0;
        high_cnt           = 0;
        last_freq          = 0;
        freq_sum           = 0;
        period_cnt         = 0;
        last_pushed        = 1'b0;
        s_taken            = 1'b0;
        m_taken            = 1'b0;
        src_burst          = 1'b0;
        snk_burst          = 1'b0;
        src_gap            = 0;
        snk_wait           = $urandom_range(0, 7);
        mismatches         = 0;
        results_checked    = 0;
        samples_seen       = 0;
        settings_used      = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset interval: seed high, first edge drops counts, shortest periods,
        // long high share
        add_levels('{1, 1, 0, 0, 0, 1, 1, 0, 1, 0, 1, 1, 1, 1, 1, 1, 0, 0});
        drain();

        // zero interval makes the divisor zero
        set_interval('0);
        add_levels('{1, 0, 1, 0, 1, 1, 0});
        drain();

        intervals[0] = 10'd1;
        intervals[1] = 10'd1000;
        intervals[2] = 10'd1023;
        intervals[3] = SPW'($urandom_range(1, 1000));
        intervals[4] = sfdm_pkg::SP_RESET;
        intervals[5] = SPW'($urandom_range(1, 1000));
        intervals[6] = 10'd1;
        foreach (intervals[i])
        begin
            set_interval(intervals[i]);
            if (i == 2 || i == 5)
            begin
                src_burst = 1'b1;
                snk_burst = 1'b1;
            end
            else
            begin
                src_burst = $urandom_range(0, 3) == 0;
                snk_burst = $urandom_range(0, 3) == 0;
            end
            gen_phase(120);
            drain();
        end

        $display("checked %0d periods from %0d samples", results_checked, samples_seen);
        $display("over %0d interval writes including zero and full scale", settings_used);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

FILE: files.f
sv/sfdm_pkg.sv
sv/sfdm_div.sv
sv/sampled_frequency_duty_meter.sv
dv/tb_top.sv
